@@ design/sliding_window_median_defines.svh @@
// Assertion macros shared by the sliding window median RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// Checked on every edge once out of reset.
`define SWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define SWM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/swm_pkg.sv @@
// Shared constants, types and helpers for the sliding window median block.
// No dependencies; imported by swm_cell, swm_chain and the top level.
package swm_pkg;

    localparam int WINDOW_MAX  = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int FIELD_W     = 16;            // width of the sample and median fields
    localparam int SUM_W       = 48;
    localparam int WSIZE_W     = 9;             // window_size register width
    localparam int TDATA_W     = 64;            // median + median_sum, whole bytes

    localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int NSLOT  = 2 ** IDX_W;
    localparam int LO_W   = IDX_W / 2;          // first select level
    localparam int HI_W   = IDX_W - LO_W;       // second select level
    localparam int GS     = 2 ** LO_W;          // entries per group
    localparam int NGRP   = 2 ** HI_W;

    // Stored entry as seen by the left neighbour.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic                   occ;
    } swm_entry_t;

    // Cell-to-cell link: the entry after removal and whether it sits past the
    // insertion point.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic                   moved;
    } swm_link_t;

    // Window length actually used: zero acts as one, large values clamp.
    function automatic logic [CNT_W-1:0] eff_window(input logic [WSIZE_W-1:0] wsize);
        logic [CNT_W-1:0] k;
        if (wsize == '0)
        begin
            k = CNT_W'(1);
        end
        else if (int'(wsize) > WINDOW_MAX)
        begin
            k = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            k = CNT_W'(wsize);
        end
        return k;
    endfunction

endpackage

@@ design/swm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/swm_cell.sv @@
// One slot of the sorted window: removes the oldest sample and inserts the
// new one using only its own entry and its two neighbours. Uses swm_pkg.
module swm_cell (
    input  logic                           clk,
    input  logic                           upd,
    input  logic                           del,
    input  logic [swm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [swm_pkg::SAMPLE_BITS-1:0] del_value,
    input  logic                           occ_self,
    input  swm_pkg::swm_entry_t            right,
    input  swm_pkg::swm_link_t             left_in,
    output swm_pkg::swm_link_t             link_out,
    output logic [swm_pkg::SAMPLE_BITS-1:0] value
);
    import swm_pkg::*;

    logic [SAMPLE_BITS-1:0] value_reg;
    logic [SAMPLE_BITS-1:0] value_next;
    logic [SAMPLE_BITS-1:0] v_ad;
    logic                   o_ad;
    logic                   at_del;
    logic                   past_ins;

    // Oldest sample is the first stored copy of its value, so every slot at or
    // after it (or empty) takes its right neighbour.
    assign at_del   = del && (!occ_self || (value_reg >= del_value));
    assign v_ad     = at_del ? right.value : value_reg;
    assign o_ad     = at_del ? right.occ   : occ_self;
    // New sample goes after stored samples of equal value.
    assign past_ins = !o_ad || (v_ad > sample);

    assign link_out.value = v_ad;
    assign link_out.moved = past_ins;

    always_comb
    begin
        if (!past_ins)
        begin
            value_next = v_ad;
        end
        else if (left_in.moved)
        begin
            value_next = left_in.value;
        end
        else
        begin
            value_next = sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

@@ design/swm_chain.sv @@
// Row of sorted-window cells plus a two-level registered select of the median slot.
// Uses swm_pkg and swm_cell.
module swm_chain (
    input  logic                            clk,
    input  logic                            upd,
    input  logic                            del,
    input  logic [swm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [swm_pkg::SAMPLE_BITS-1:0] del_value,
    input  logic [swm_pkg::CNT_W-1:0]       fill,
    input  logic [swm_pkg::IDX_W-1:0]       med_idx,
    output logic [swm_pkg::SAMPLE_BITS-1:0] median
);
    import swm_pkg::*;

    localparam logic [IDX_W-1:0] LO_MASK = IDX_W'(GS - 1);

    swm_link_t              links [WINDOW_MAX+1];
    swm_entry_t             ents  [WINDOW_MAX+1];
    logic [SAMPLE_BITS-1:0] slot_vals [NSLOT];
    logic [SAMPLE_BITS-1:0] grp_reg   [NGRP];

    assign links[0] = '{value: '0, moved: 1'b0};
    assign ents[WINDOW_MAX] = '{value: '0, occ: 1'b0};

    genvar j;
    generate
        for (j = 0; j < WINDOW_MAX; j++)
        begin : g_cell
            logic [SAMPLE_BITS-1:0] cval;

            assign ents[j].value = cval;
            assign ents[j].occ   = (int'(fill) > j);

            swm_cell u_cell (
                .clk       (clk),
                .upd       (upd),
                .del       (del),
                .sample    (sample),
                .del_value (del_value),
                .occ_self  (ents[j].occ),
                .right     (ents[j+1]),
                .left_in   (links[j]),
                .link_out  (links[j+1]),
                .value     (cval)
            );
        end

        for (j = 0; j < NSLOT; j++)
        begin : g_slot
            if (j < WINDOW_MAX)
            begin : g_used
                assign slot_vals[j] = ents[j].value;
            end
            else
            begin : g_pad
                assign slot_vals[j] = '0;
            end
        end
    endgenerate

    // First level: one entry out of each group, captured every cycle.
    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_reg[g] <= slot_vals[IDX_W'(g * GS) | (med_idx & LO_MASK)];
        end
    end

    assign median = grp_reg[HI_W'(med_idx >> LO_W)];

endmodule

@@ design/sliding_window_median.sv @@
// Sliding window running median: one unsigned sample per item in, one result per item out.
// Channels: s_* takes items (tdata = sample, tlast = last sample of a stream);
//   m_* gives results (tdata = median, median_sum; tuser = median_valid;
//   tlast = stream_done); cfg_* writes window_size, which also clears the window and sum.
// Flow: an accepted item moves through stage one, then stage two, then the output register.
// One item is in flight at a time, the next taken once the last leaves stage two; the sorted cell
//   row updates on accept, then a two-level registered select picks the median and the sum is added.
// The oldest sample of the window comes from a 256-entry sample history RAM read ahead of each
//   item, so each removal needs no search over the window.
// When the receiver stalls, the finished item waits in the output register and the next
//   item is still accepted; its result waits one stage back until the output frees.
// Reset: window_size = 3, window empty, sum zero, no result pending. The cell row and
//   history RAM need no clearing: only slots below the fill count are used.
// Configuration may only be written with no item in flight; cfg_ready is always high.
// Uses swm_pkg, swm_chain, swm_ram and sliding_window_median_defines.svh.
`include "sliding_window_median_defines.svh"

module sliding_window_median (
    input  logic                        clk,
    input  logic                        rst_n,
    // config: window_size
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [swm_pkg::WSIZE_W-1:0] cfg_data,
    // input items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [swm_pkg::FIELD_W-1:0] s_tdata,    // [15:0] sample
    input  logic                        s_tlast,    // last_sample
    // results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [swm_pkg::TDATA_W-1:0] m_tdata,    // [15:0] median, [63:16] median_sum
    output logic                        m_tuser,    // median_valid
    output logic                        m_tlast     // stream_done
);
    import swm_pkg::*;

    logic [WSIZE_W-1:0]     wsize_reg;
    logic [CNT_W-1:0]       fill_reg;
    logic [CNT_W-1:0]       fill_next;
    logic [IDX_W-1:0]       wptr_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [SUM_W:0]         sum_add;

    // pipeline control
    logic p1_reg, p2_reg;
    logic p1_valid_reg, p1_last_reg;
    logic p2_valid_reg, p2_last_reg;
    logic out_valid_reg;

    // output payload
    logic [FIELD_W-1:0]     med_out_reg;
    logic [SUM_W-1:0]       sum_out_reg;
    logic                   valid_out_reg;
    logic                   last_out_reg;

    logic                   accept;
    logic                   out_take;
    logic                   del;
    logic [CNT_W-1:0]       keff;
    logic [CNT_W:0]         kp1;
    logic [IDX_W-1:0]       med_idx;
    logic [SAMPLE_BITS-1:0] sample;
    logic [SAMPLE_BITS-1:0] oldest;
    logic [SAMPLE_BITS-1:0] med_sel;
    logic [FIELD_W-1:0]     med_val;

    assign keff    = eff_window(wsize_reg);
    assign kp1     = {1'b0, keff} + (CNT_W+1)'(1);
    assign med_idx = IDX_W'((kp1 >> 1) - (CNT_W+1)'(1));   // lower median slot

    assign sample  = s_tdata[SAMPLE_BITS-1:0];
    assign cfg_ready = 1'b1;
    // one item in the cell row / select stages at a time
    assign s_tready  = !p1_reg && !p2_reg;
    assign accept    = s_tvalid && s_tready;
    assign out_take  = p2_reg && (!out_valid_reg || m_tready);

    // a full window drops its oldest sample before the new one goes in
    assign del       = (fill_reg >= keff);
    assign fill_next = del ? fill_reg : fill_reg + CNT_W'(1);

    // sample history: the entry written keff items ago is the one leaving
    swm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (NSLOT)
    ) u_hist (
        .clk   (clk),
        .we    (accept),
        .waddr (wptr_reg),
        .wdata (sample),
        .raddr (wptr_reg - keff[IDX_W-1:0]),
        .rdata (oldest)
    );

    swm_chain u_chain (
        .clk       (clk),
        .upd       (accept),
        .del       (del),
        .sample    (sample),
        .del_value (oldest),
        .fill      (fill_reg),
        .med_idx   (med_idx),
        .median    (med_sel)
    );

    assign med_val = p2_valid_reg ? FIELD_W'(med_sel) : '0;
    assign sum_add = {1'b0, sum_reg} + (SUM_W+1)'(med_val);
    // saturate on carry out
    assign sum_next = !p2_valid_reg ? sum_reg :
                      (sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsize_reg     <= WSIZE_W'(3);
            fill_reg      <= '0;
            wptr_reg      <= '0;
            sum_reg       <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                wsize_reg <= cfg_data;
                fill_reg  <= '0;
                sum_reg   <= '0;
            end
            else
            begin
                if (accept)
                begin
                    fill_reg <= s_tlast ? '0 : fill_next;
                end
                if (out_take)
                begin
                    sum_reg <= p2_last_reg ? '0 : sum_next;
                end
            end

            if (accept)
            begin
                wptr_reg <= wptr_reg + IDX_W'(1);
            end

            p1_reg <= accept;
            if (p1_reg)
            begin
                p2_reg <= 1'b1;
            end
            else if (out_take)
            begin
                p2_reg <= 1'b0;
            end

            if (out_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload side bands, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_valid_reg <= (fill_next >= keff);
            p1_last_reg  <= s_tlast;
        end
        if (p1_reg)
        begin
            p2_valid_reg <= p1_valid_reg;
            p2_last_reg  <= p1_last_reg;
        end
        if (out_take)
        begin
            med_out_reg   <= med_val;
            sum_out_reg   <= sum_next;
            valid_out_reg <= p2_valid_reg;
            last_out_reg  <= p2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {sum_out_reg, med_out_reg};
    assign m_tuser  = valid_out_reg;
    assign m_tlast  = last_out_reg;

    `SWM_ASSERT(a_fill_bound, fill_reg <= keff, "fill count above window length")
    `SWM_ASSERT(a_one_in_flight, !(p1_reg && p2_reg), "two items in the select stages")
    `SWM_ASSERT(a_accept_enters, accept |=> p1_reg, "accepted item did not enter stage one")
    `SWM_ASSERT(a_short_zero, (m_tvalid && !m_tuser) |-> (m_tdata == '0),
                "result without a full window is not zero")

endmodule

@@ test/testbench.sv @@
// Self-checking bench for sliding_window_median: random sample streams against an in-bench
// running median predictor. Depends on swm_pkg and the sliding_window_median RTL only.
`timescale 1ns / 1ps

module testbench;

    import swm_pkg::*;

    localparam int LONG_HOLD   = 300;      // receiver hold-off to fill the block up
    localparam int STALL_LIMIT = 3000;     // cycles with no handshake before giving up
    localparam int DRAIN_WAIT  = 8;        // extra wait after all results have drained, as margin
    localparam logic [SUM_W-1:0] SUM_TOP = '1;

    // One result item as the block should give it.
    typedef struct packed {
        logic                   valid;
        logic [FIELD_W-1:0]     median;
        logic [SUM_W-1:0]       sum;
        logic                   done;
    } median_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [WSIZE_W-1:0]     cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [FIELD_W-1:0]     s_tdata = '0;       // [15:0] sample
    logic                   s_tlast = 1'b0;     // last_sample
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;            // [15:0] median, [63:16] median_sum
    logic                   m_tuser;            // median_valid
    logic                   m_tlast;            // stream_done

    // Predictor state: window in arrival order and the same samples kept sorted.
    logic [WSIZE_W-1:0]     window_reg = WSIZE_W'(3);
    logic [FIELD_W-1:0]     arrival_window[$];
    logic [FIELD_W-1:0]     ordered_window[$];
    logic [SUM_W-1:0]       median_total = '0;
    median_result_t         pending_results[$];

    int                     fail_count = 0;
    int                     quiet_cycles = 0;
    bit                     tx_calm = 1'b0;     // sender offers back to back when set
    bit                     rx_calm = 1'b0;     // receiver always ready when set
    int                     holds_asked = 0;
    int                     holds_served = 0;
    int                     rx_wait = 0;
    median_result_t         want;

    sliding_window_median u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, some short ones, the odd long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Window length the block should use: zero behaves as one, oversize clamps.
    function automatic int window_length(input logic [WSIZE_W-1:0] ws);
        if (ws == '0)
        begin
            return 1;
        end
        if (int'(ws) > WINDOW_MAX)
        begin
            return WINDOW_MAX;
        end
        return int'(ws);
    endfunction

    // Random sample with a bias towards extremes and repeated values.
    function automatic logic [FIELD_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0:       return '0;
            1:       return '1;
            2:       return FIELD_W'(16'h8000);
            3, 4:    return FIELD_W'($urandom_range(0, 7));
            default: return FIELD_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Push one sample through the predictor and queue the result it should give.
    task automatic predict_median(input logic [FIELD_W-1:0] smp, input logic last);
        int k;
        int i;
        logic [FIELD_W-1:0] oldest;
        median_result_t r;
        k = window_length(window_reg);
        while (arrival_window.size() >= k)
        begin
            oldest = arrival_window.pop_front();
            i = 0;
            while (ordered_window[i] != oldest)
                i++;
            ordered_window.delete(i);
        end
        arrival_window.insert(arrival_window.size(), smp);
        // equal values go after those already stored
        i = 0;
        while (i < ordered_window.size() && ordered_window[i] <= smp)
            i++;
        ordered_window.insert(i, smp);
        r.valid  = (arrival_window.size() >= k);
        r.median = r.valid ? ordered_window[(k + 1) / 2 - 1] : '0;
        if (r.valid)
        begin
            if (median_total > SUM_TOP - SUM_W'(r.median))
                median_total = SUM_TOP;
            else
                median_total = median_total + SUM_W'(r.median);
        end
        r.sum  = median_total;
        r.done = last;
        pending_results.insert(pending_results.size(), r);
        if (last)
        begin
            arrival_window.delete();
            ordered_window.delete();
            median_total = '0;
        end
    endtask

    // Offer one item and wait for it to be taken; tvalid stays up for a following item.
    task automatic send_sample(input logic [FIELD_W-1:0] smp, input logic last);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_median(smp, last);
    endtask

    // Stop offering and let every outstanding result drain, then wait out the drain margin.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Write window_size; the block must be idle, and the write clears window and sum.
    task automatic write_window(input logic [WSIZE_W-1:0] ws);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= ws;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        window_reg = ws;
        arrival_window.delete();
        ordered_window.delete();
        median_total = '0;
    endtask

    // A stream of random samples; last marks come at random, the final item always ends it.
    task automatic send_stream_mix(input int n);
        int k;
        logic last;
        k = window_length(window_reg);
        for (int i = 0; i < n; i++)
        begin
            last = (i == n - 1) || ($urandom_range(0, 2 * k + 8) == 0);
            send_sample(pick_sample(), last);
        end
    endtask

    // Reset window of three: extremes, then a stream shorter than the window.
    task automatic test_reset_window();
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample(FIELD_W'(16'h8000), 1'b0);
        send_sample(FIELD_W'(16'h7FFF), 1'b0);
        send_sample('1, 1'b0);
        send_sample('0, 1'b1);
        send_sample(FIELD_W'(16'h1234), 1'b1);
    endtask

    // Window size zero behaves as one.
    task automatic test_window_zero();
        write_window('0);
        send_sample('1, 1'b0);
        send_sample(FIELD_W'(1), 1'b1);
    endtask

    // All-ones size clamps to the maximum; a short stream never gives a median.
    task automatic test_window_clamp();
        write_window('1);
        send_sample(FIELD_W'(16'hAAAA), 1'b0);
        send_sample(FIELD_W'(16'h5555), 1'b0);
        send_sample('1, 1'b1);
    endtask

    // Even window with duplicates: lower median, equal samples in any order.
    task automatic test_equal_values();
        write_window(WSIZE_W'(4));
        send_sample(FIELD_W'(7), 1'b0);
        send_sample(FIELD_W'(7), 1'b0);
        send_sample(FIELD_W'(7), 1'b0);
        send_sample(FIELD_W'(7), 1'b0);
        send_sample(FIELD_W'(3), 1'b0);
        send_sample(FIELD_W'(7), 1'b0);
        send_sample(FIELD_W'(9), 1'b1);
    endtask

    // A write in the middle of a stream drops the partial window and sum.
    task automatic test_write_clears();
        write_window(WSIZE_W'(2));
        send_sample(FIELD_W'(100), 1'b0);
        send_sample(FIELD_W'(200), 1'b0);
        send_sample(FIELD_W'(300), 1'b0);
        write_window(WSIZE_W'(2));
        send_sample(FIELD_W'(50), 1'b0);
        send_sample(FIELD_W'(60), 1'b1);
    endtask

    // Receiver holds off for a long stretch while items keep coming back to back.
    task automatic test_backpressure();
        write_window(WSIZE_W'(3));
        tx_calm = 1'b1;
        holds_asked <= holds_asked + 1;
        send_stream_mix(40);
        tx_calm = 1'b0;
    endtask

    // Small and middling windows, each with its own mix of idling.
    task automatic test_random_small();
        logic [WSIZE_W-1:0] ws;
        for (int s = 0; s < 8; s++)
        begin
            case (s)
                0:       ws = WSIZE_W'(1);
                1:       ws = WSIZE_W'(2);
                2:       ws = WSIZE_W'(7);
                3:       ws = WSIZE_W'($urandom_range(9, 40));
                4:       ws = WSIZE_W'($urandom_range(1, 64));
                default: ws = WSIZE_W'($urandom_range(1, 16));
            endcase
            write_window(ws);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            send_stream_mix($urandom_range(18, 28));
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // Full-size window: one stream long enough to fill it and slide past.
    task automatic test_random_large();
        write_window(WSIZE_W'(WINDOW_MAX));
        for (int i = 0; i < WINDOW_MAX + 14; i++)
            send_sample(pick_sample(), i == WINDOW_MAX + 13);
    endtask

    // Receiver: random stalls, plus one long hold-off whenever a test asks for it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            rx_wait      <= 0;
            holds_served <= 0;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served <= holds_served + 1;
            rx_wait      <= LONG_HOLD;
            m_tready     <= 1'b0;
        end
        else if (rx_wait != 0)
        begin
            rx_wait  <= rx_wait - 1;
            m_tready <= 1'b0;
        end
        else if (rx_calm || $urandom_range(0, 3) != 0)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            m_tready <= 1'b0;
            rx_wait  <= pick_gap();
        end
    end

    // Result checker: every taken result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with none expected: median=%0d sum=%0d",
                       m_tdata[FIELD_W-1:0], m_tdata[TDATA_W-1:FIELD_W]);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.valid)
                begin
                    $error("median_valid: expected %0d, got %0d", want.valid, m_tuser);
                    fail_count++;
                end
                if (m_tdata[FIELD_W-1:0] !== want.median)
                begin
                    $error("median: expected %0d, got %0d", want.median,
                           m_tdata[FIELD_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[TDATA_W-1:FIELD_W] !== want.sum)
                begin
                    $error("median_sum: expected %0d, got %0d", want.sum,
                           m_tdata[TDATA_W-1:FIELD_W]);
                    fail_count++;
                end
                if (m_tlast !== want.done)
                begin
                    $error("stream_done: expected %0d, got %0d", want.done, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long without any handshake on any channel ends the run.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("sliding_window_median: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_window_zero();
        test_window_clamp();
        test_equal_values();
        test_write_clears();
        test_backpressure();
        test_random_small();
        test_random_large();

        settle();
        if (fail_count == 0)
        begin
            $display("sliding_window_median: match");
        end
        else
        begin
            $display("sliding_window_median: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/swm_pkg.sv
design/swm_ram.sv
design/swm_cell.sv
design/swm_chain.sv
design/sliding_window_median.sv
test/testbench.sv
